// ----- sv/ssff_pkg.sv -----
`default_nettype none

package ssff_pkg;

  // Fixed-point layout of the smoothing accumulators.
  localparam int FRAC_BITS     = 16;
  localparam int ACC_W         = 18 + FRAC_BITS;
  localparam int INT_W         = ACC_W - FRAC_BITS;
  localparam int PRIME_SAMPLES = 2;
  localparam int PRIME_W       = 2;

  // Field widths.
  localparam int RAW_W      = 16;
  localparam int ALPHA_W    = 16;
  localparam int OFF_W      = 16;
  localparam int TEMP_OUT_W = 8;
  localparam int PRES_OUT_W = 16;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Shifts that move a Q0.16 offset onto the accumulator's fraction bits.
  localparam int OFF_LSH = (FRAC_BITS >= OFF_W) ? (FRAC_BITS - OFF_W) : 0;
  localparam int OFF_RSH = (FRAC_BITS >= OFF_W) ? 0 : (OFF_W - FRAC_BITS);

  typedef enum logic [2:0] {
    REG_INV_LEVEL   = 3'd0,
    REG_IMB_LEVEL   = 3'd1,
    REG_DOOR_LEVEL  = 3'd2,
    REG_TEMP_ALPHA  = 3'd3,
    REG_PRES_ALPHA  = 3'd4,
    REG_TEMP_OFFSET = 3'd5,
    REG_PRES_OFFSET = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic               inverter_bit;
    logic               imbalance_bit;
    logic               door_bit;
    logic [RAW_W-1:0]   raw_temperature;
    logic [RAW_W-1:0]   raw_pressure;
  } in_t;

  typedef struct packed {
    logic                  inverter_fault;
    logic                  imbalance_fault;
    logic                  door_fault;
    logic                  any_fault;
    logic [TEMP_OUT_W-1:0] smoothed_temperature;
    logic [PRES_OUT_W-1:0] smoothed_pressure;
  } out_t;

  typedef struct packed {
    logic                inverter_fault_level;
    logic                imbalance_fault_level;
    logic                door_closed_level;
    logic [ALPHA_W-1:0]  temp_alpha;
    logic [ALPHA_W-1:0]  pres_alpha;
    logic [OFF_W-1:0]    temp_offset;
    logic [OFF_W-1:0]    pres_offset;
  } cfg_t;

  typedef struct packed {
    logic inverter_fault;
    logic imbalance_fault;
    logic door_fault;
    logic any_fault;
  } flags_t;

  // Offset aligned to the accumulator's fraction bits.
  function automatic logic [ACC_W-1:0] off_to_fixed(input logic [OFF_W-1:0] off);
    logic [ACC_W-1:0] wide;
    wide = ACC_W'(off);
    return (wide >> OFF_RSH) << OFF_LSH;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ssff_cfg_regs.sv -----
`default_nettype none

module ssff_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ssff_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssff_pkg::DATA_W-1:0] pwdata,
  output logic      [ssff_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output ssff_pkg::cfg_t                   cfg
);

  ssff_pkg::cfg_t     cfg_r;
  ssff_pkg::cfg_t     cfg_nxt;
  ssff_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = ssff_pkg::reg_idx_t'(paddr[ssff_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write decode; indexes past the last register are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        ssff_pkg::REG_INV_LEVEL:   cfg_nxt.inverter_fault_level  = pwdata[0];
        ssff_pkg::REG_IMB_LEVEL:   cfg_nxt.imbalance_fault_level = pwdata[0];
        ssff_pkg::REG_DOOR_LEVEL:  cfg_nxt.door_closed_level     = pwdata[0];
        ssff_pkg::REG_TEMP_ALPHA:  cfg_nxt.temp_alpha  = pwdata[ssff_pkg::ALPHA_W-1:0];
        ssff_pkg::REG_PRES_ALPHA:  cfg_nxt.pres_alpha  = pwdata[ssff_pkg::ALPHA_W-1:0];
        ssff_pkg::REG_TEMP_OFFSET: cfg_nxt.temp_offset = pwdata[ssff_pkg::OFF_W-1:0];
        ssff_pkg::REG_PRES_OFFSET: cfg_nxt.pres_offset = pwdata[ssff_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inverter_fault_level  <= 1'b1;
      cfg_r.imbalance_fault_level <= 1'b1;
      cfg_r.door_closed_level     <= 1'b1;
      cfg_r.temp_alpha            <= ssff_pkg::ALPHA_W'(5898);
      cfg_r.pres_alpha            <= ssff_pkg::ALPHA_W'(5243);
      cfg_r.temp_offset           <= ssff_pkg::OFF_W'(19661);
      cfg_r.pres_offset           <= ssff_pkg::OFF_W'(19661);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    unique case (idx)
      ssff_pkg::REG_INV_LEVEL:   prdata = ssff_pkg::DATA_W'(cfg_r.inverter_fault_level);
      ssff_pkg::REG_IMB_LEVEL:   prdata = ssff_pkg::DATA_W'(cfg_r.imbalance_fault_level);
      ssff_pkg::REG_DOOR_LEVEL:  prdata = ssff_pkg::DATA_W'(cfg_r.door_closed_level);
      ssff_pkg::REG_TEMP_ALPHA:  prdata = ssff_pkg::DATA_W'(cfg_r.temp_alpha);
      ssff_pkg::REG_PRES_ALPHA:  prdata = ssff_pkg::DATA_W'(cfg_r.pres_alpha);
      ssff_pkg::REG_TEMP_OFFSET: prdata = ssff_pkg::DATA_W'(cfg_r.temp_offset);
      ssff_pkg::REG_PRES_OFFSET: prdata = ssff_pkg::DATA_W'(cfg_r.pres_offset);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/ssff_fault_flags.sv -----
`default_nettype none

module ssff_fault_flags (
  input  wire ssff_pkg::in_t  sample,
  input  wire ssff_pkg::cfg_t cfg,
  output ssff_pkg::flags_t    flags
);

  // Inverter and imbalance fault on a match, the door on a mismatch.
  always_comb begin
    flags.inverter_fault  = ~(sample.inverter_bit ^ cfg.inverter_fault_level);
    flags.imbalance_fault = ~(sample.imbalance_bit ^ cfg.imbalance_fault_level);
    flags.door_fault      = sample.door_bit ^ cfg.door_closed_level;
    flags.any_fault       = flags.inverter_fault | flags.imbalance_fault |
                            flags.door_fault;
  end

endmodule

`default_nettype wire

// ----- sv/ssff_iir_channel.sv -----
`default_nettype none

module ssff_iir_channel (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic                         load,
  input  wire logic [ssff_pkg::ALPHA_W-1:0] alpha,
  input  wire logic [ssff_pkg::OFF_W-1:0]   offset,
  input  wire logic [ssff_pkg::RAW_W-1:0]   x,
  output logic      [ssff_pkg::INT_W-1:0]   int_part
);

  localparam int ACC_W  = ssff_pkg::ACC_W;
  localparam int SUM_W  = ACC_W + 2;
  localparam int PROD_W = ssff_pkg::ALPHA_W + ACC_W + 2;

  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_nxt;
  logic [ACC_W-1:0]         x_fix;
  logic signed [ACC_W:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc_ext;
  logic signed [SUM_W-1:0]  off_ext;
  logic signed [SUM_W-1:0]  step_ext;
  logic signed [SUM_W-1:0]  sum;
  logic [ACC_W-1:0]         filt;

  // (65536 - a)*y + a*x over 65536 equals y + a*(x - y)/65536, with the
  // floor carried by the arithmetic shift since 65536*y divides exactly.
  always_comb begin
    x_fix    = ACC_W'(x) << ssff_pkg::FRAC_BITS;
    diff     = $signed({1'b0, x_fix}) - $signed({1'b0, acc_r});
    prod     = $signed({1'b0, alpha}) * diff;
    step_ext = $signed(prod[ssff_pkg::ALPHA_W +: SUM_W]);
    acc_ext  = $signed({2'b00, acc_r});
    off_ext  = $signed({2'b00, ssff_pkg::off_to_fixed(offset)});
    sum      = acc_ext + step_ext + off_ext;
  end

  // The sum is never negative; saturate at the accumulator's full scale.
  always_comb begin
    if (sum[SUM_W-1:ACC_W] != '0) begin
      filt = '1;
    end else begin
      filt = sum[ACC_W-1:0];
    end
  end

  // Priming loads the raw value directly.
  always_comb begin
    if (load) begin
      acc_nxt = x_fix;
    end else begin
      acc_nxt = filt;
    end
  end

  assign int_part = acc_nxt[ACC_W-1:ssff_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (step) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sensor_smoothing_and_fault_flags_unit.sv -----
// A beat accepted into the input stage register moves on to the output register once that can take it.
// Throughput: one beat per cycle while out_stall is low; the accumulator update is a
// combinational multiply-add per channel, closed through the accumulator register.
// Reset (rst_n, synchronous, active low) empties both stages, clears the
// accumulators, restarts priming and restores the register defaults.
`default_nettype none

module sensor_smoothing_and_fault_flags_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire ssff_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ssff_pkg::out_t                   out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ssff_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssff_pkg::DATA_W-1:0] pwdata,
  output logic      [ssff_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int INT_W   = ssff_pkg::INT_W;
  localparam int PRIME_W = ssff_pkg::PRIME_W;

  ssff_pkg::cfg_t   cfg;
  ssff_pkg::flags_t flags;
  ssff_pkg::in_t    s1_data_r;
  ssff_pkg::out_t   out_data_r;
  ssff_pkg::out_t   out_data_nxt;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             s1_adv;
  logic             in_take;
  logic             priming;
  logic [PRIME_W-1:0] prime_cnt_r;
  logic [PRIME_W-1:0] prime_cnt_nxt;
  logic [INT_W-1:0] temp_int;
  logic [INT_W-1:0] pres_int;

  ssff_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the input stage moves on whenever the output register is empty or not stalled.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign priming  = (prime_cnt_r != '0);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end
    prime_cnt_nxt = prime_cnt_r;
    if (s1_adv && priming) begin
      prime_cnt_nxt = prime_cnt_r - PRIME_W'(1);
    end
  end

  ssff_fault_flags u_flags (
    .sample (s1_data_r),
    .cfg    (cfg),
    .flags  (flags)
  );

  ssff_iir_channel u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .load     (priming),
    .alpha    (cfg.temp_alpha),
    .offset   (cfg.temp_offset),
    .x        (s1_data_r.raw_temperature),
    .int_part (temp_int)
  );

  ssff_iir_channel u_pres (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .load     (priming),
    .alpha    (cfg.pres_alpha),
    .offset   (cfg.pres_offset),
    .x        (s1_data_r.raw_pressure),
    .int_part (pres_int)
  );

  // Result beat with the integer parts saturated to the output widths.
  always_comb begin
    out_data_nxt.inverter_fault  = flags.inverter_fault;
    out_data_nxt.imbalance_fault = flags.imbalance_fault;
    out_data_nxt.door_fault      = flags.door_fault;
    out_data_nxt.any_fault       = flags.any_fault;
    if (temp_int[INT_W-1:ssff_pkg::TEMP_OUT_W] != '0) begin
      out_data_nxt.smoothed_temperature = '1;
    end else begin
      out_data_nxt.smoothed_temperature = temp_int[ssff_pkg::TEMP_OUT_W-1:0];
    end
    if (pres_int[INT_W-1:ssff_pkg::PRES_OUT_W] != '0) begin
      out_data_nxt.smoothed_pressure = '1;
    end else begin
      out_data_nxt.smoothed_pressure = pres_int[ssff_pkg::PRES_OUT_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prime_cnt_r <= PRIME_W'(ssff_pkg::PRIME_SAMPLES);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      prime_cnt_r <= prime_cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Once priming is over it never restarts short of a reset.
  a_prime_done: assert property (@(posedge clk) disable iff (!rst_n)
    (prime_cnt_r == '0) |=> (prime_cnt_r == '0))
    else $error("priming count restarted");

  // The priming count only moves when a beat leaves the input stage.
  a_prime_step: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(prime_cnt_r))
    else $error("priming count moved without a beat");

  // Input is held off only while both stages are full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  // A beat that leaves the input stage lands in the output register.
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat lost");

endmodule

`default_nettype wire
